### design/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Shared types, constants and helpers for the 4-bit character LCD interface.
// ----------------------------------------------------------------------------
package lcd4_pkg;

  // Command modes
  localparam logic [1:0] MODE_SEND   = 2'd0;
  localparam logic [1:0] MODE_INIT   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  // Config register map
  localparam logic CFG_IDX_CPU = 1'b0;
  localparam logic [7:0] CPU_RESET = 8'd50;

  // Instruction bytes and address bases
  localparam logic [7:0] INS_CLEAR    = 8'h01;
  localparam logic [7:0] INS_FUNC_4B  = 8'h28;
  localparam logic [7:0] INS_DISP_ON  = 8'h0c;
  localparam logic [7:0] INS_ENTRY    = 8'h06;
  localparam logic [7:0] BASE_LINE1   = 8'h80;
  localparam logic [7:0] BASE_LINE2   = 8'hc0;
  localparam logic [1:0] LINE_ONE     = 2'd1;
  localparam logic [1:0] LINE_TWO     = 2'd2;

  // Hold times in microseconds
  localparam logic [12:0] HOLD_SETUP  = 13'd100;
  localparam logic [12:0] HOLD_PULSE  = 13'd25;
  localparam logic [12:0] HOLD_NONE   = 13'd0;
  localparam logic [12:0] HOLD_TAIL   = 13'd40;
  localparam logic [12:0] HOLD_CLEAR  = 13'd2040;
  localparam logic [12:0] HOLD_POWER  = 13'd5000;
  localparam logic [12:0] HOLD_WAKE2  = 13'd1000;

  // Power-up sequence segments
  localparam logic [2:0] SEG_POWER    = 3'd0;
  localparam logic [2:0] SEG_NIB_LAST = 3'd3;
  localparam logic [2:0] SEG_CLEAR    = 3'd6;
  localparam logic [2:0] SEG_FINAL    = 3'd7;

  // Phase index inside a segment
  localparam logic [2:0] SUB_SETUP    = 3'd0;
  localparam logic [2:0] SUB_HI_EN    = 3'd1;
  localparam logic [2:0] SUB_HI_OFF   = 3'd2;
  localparam logic [2:0] SUB_LO_EN    = 3'd3;
  localparam logic [2:0] SUB_LO_OFF   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_HOLD
  } lcd4_state_e;

  typedef struct packed {
    logic        start;
    logic [12:0] hold_us;
  } lcd4_tmr_req_t;

  // Byte sent by byte segment 4..7 of the power-up sequence
  function automatic logic [7:0] init_byte(input logic [2:0] seg);
    logic [7:0] b;
    unique case (seg[1:0])
      2'd0:    b = INS_FUNC_4B;
      2'd1:    b = INS_DISP_ON;
      2'd2:    b = INS_CLEAR;
      default: b = INS_ENTRY;
    endcase
    return b;
  endfunction

endpackage

### design/char_lcd_nibble_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// HD44780-style 4-bit LCD driver: turns commands into timed pin phases.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one command item: tuser = {register_select, mode},
//    tdata = {column_offset, line_number, data_byte}. tready is high only
//    while the block is idle.
//  - Master stream gives one item per pin phase: rs, enable, data lines and
//    hold time; tlast marks the final phase of the command. Send, clear and
//    cursor give 5 phases, initialise gives 27.
//  - After each phase item is taken, the phase is held for hold_time_us
//    microseconds, counted by one shared timer whose prescaler is set by
//    clocks_per_microsecond. A zero hold time or a zero rate gives no wait.
//  - A stalled master holds the phase item; the hold starts once taken.
//  - Reset: pins go low, rate register to 50, block idle and ready.
//  - Config: APB register 0 at address 0, clocks_per_microsecond[7:0].
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [9:8] line_number,
                                     // [17:10] column_offset, rest zero
  input  logic [2:0]  s_axis_tuser,  // [1:0] mode, [2] register_select
  // phase stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [0] rs_pin, [1] enable_pin,
                                     // [5:2] data_pins, [18:6] hold_time_us
  output logic        m_axis_tlast   // last_phase
);
  import lcd4_pkg::*;

  lcd4_state_e state_q, state_d;

  logic [7:0] cpu_q;
  logic       rs_q;       // current rs pin level
  logic [3:0] dat_q;      // current data pin levels

  // command latched at accept
  logic       init_q;
  logic       clear_q;
  logic       sel_q;
  logic [7:0] byte_q;

  logic [2:0] seg_q, seg_d;
  logic [2:0] sub_q, sub_d;

  lcd4_tmr_req_t tmr_req;
  logic          tmr_busy;

  // ---------------------------------------------------------------- APB
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_CPU) ? {24'd0, cpu_q} : 32'd0;

  // ---------------------------------------------------------------- input
  logic [1:0] in_mode;
  logic       in_sel;
  logic [7:0] in_byte;
  logic [1:0] in_line;
  logic [7:0] in_col;
  logic [7:0] cur_base;
  logic       in_acc;

  assign in_mode = s_axis_tuser[1:0];
  assign in_sel  = s_axis_tuser[2];
  assign in_byte = s_axis_tdata[7:0];
  assign in_line = s_axis_tdata[9:8];
  assign in_col  = s_axis_tdata[17:10];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    priority if (in_line == LINE_ONE) cur_base = BASE_LINE1;
    else if (in_line == LINE_TWO)     cur_base = BASE_LINE2;
    else                              cur_base = 8'h00;
  end

  // ---------------------------------------------------------------- phase
  logic        is_power, is_nib, seg_last_sub, ph_last;
  logic [7:0]  cur_byte;
  logic        cur_tail, cur_sel;
  logic        ph_rs, ph_en;
  logic [3:0]  ph_dat;
  logic [12:0] ph_hold;
  logic [3:0]  nib_val;
  logic [12:0] nib_after;

  always_comb begin
    is_power  = init_q && (seg_q == SEG_POWER);
    is_nib    = init_q && (seg_q != SEG_POWER) && (seg_q <= SEG_NIB_LAST);
    cur_byte  = init_q ? init_byte(seg_q) : byte_q;
    cur_tail  = init_q ? (seg_q == SEG_CLEAR) : clear_q;
    cur_sel   = init_q ? 1'b0 : sel_q;
    nib_val   = (seg_q == SEG_NIB_LAST) ? 4'h2 : 4'h3;
    nib_after = (seg_q == SEG_NIB_LAST) ? HOLD_WAKE2 : HOLD_POWER;

    ph_rs = rs_q;
    ph_en = 1'b0;
    ph_dat = dat_q;
    ph_hold = HOLD_NONE;
    seg_last_sub = 1'b0;
    if (is_power) begin
      ph_dat = 4'h0;
      ph_hold = HOLD_POWER;
      seg_last_sub = 1'b1;
    end else if (is_nib) begin
      ph_en = (sub_q == SUB_SETUP);
      ph_dat = nib_val;
      ph_hold = ph_en ? HOLD_PULSE : nib_after;
      seg_last_sub = (sub_q != SUB_SETUP);
    end else begin
      unique case (sub_q)
        SUB_SETUP: begin
          ph_rs = cur_sel;
          ph_hold = HOLD_SETUP;
        end
        SUB_HI_EN: begin
          ph_en = 1'b1;
          ph_dat = cur_byte[7:4];
          ph_hold = HOLD_PULSE;
        end
        SUB_HI_OFF: begin
          ph_dat = cur_byte[7:4];
        end
        SUB_LO_EN: begin
          ph_en = 1'b1;
          ph_dat = cur_byte[3:0];
          ph_hold = HOLD_PULSE;
        end
        default: begin
          ph_dat = cur_byte[3:0];
          ph_hold = cur_tail ? HOLD_CLEAR : HOLD_TAIL;
          seg_last_sub = 1'b1;
        end
      endcase
    end
    ph_last = seg_last_sub && (!init_q || (seg_q == SEG_FINAL));
  end

  // ---------------------------------------------------------------- sequencer
  logic out_acc;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    sub_d   = sub_q;
    tmr_req.start   = 1'b0;
    tmr_req.hold_us = ph_hold;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EMIT;
          seg_d   = SEG_POWER;
          sub_d   = SUB_SETUP;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          tmr_req.start = 1'b1;
          state_d = ST_HOLD;
        end
      end
      default: begin
        if (!tmr_busy) begin
          if (ph_last) begin
            state_d = ST_IDLE;
          end else if (seg_last_sub) begin
            seg_d   = seg_q + 3'd1;
            sub_d   = SUB_SETUP;
            state_d = ST_EMIT;
          end else begin
            sub_d   = sub_q + 3'd1;
            state_d = ST_EMIT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= '0;
      sub_q   <= '0;
      cpu_q   <= CPU_RESET;
      rs_q    <= 1'b0;
      dat_q   <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      sub_q   <= sub_d;
      if (cfg_wr && (paddr[2] == CFG_IDX_CPU)) begin
        cpu_q <= pwdata[7:0];
      end
      if (out_acc) begin
        rs_q  <= ph_rs;
        dat_q <= ph_dat;
      end
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      init_q  <= (in_mode == MODE_INIT);
      clear_q <= (in_mode == MODE_CLEAR);
      sel_q   <= (in_mode == MODE_SEND) ? in_sel : 1'b0;
      unique case (in_mode)
        MODE_SEND:   byte_q <= in_byte;
        MODE_CURSOR: byte_q <= cur_base + in_col;
        default:     byte_q <= INS_CLEAR;
      endcase
    end
  end

  lcd4_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cpu_i  (cpu_q),
    .req_i  (tmr_req),
    .busy_o (tmr_busy)
  );

  // ---------------------------------------------------------------- ports
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {5'd0, ph_hold, ph_dat, ph_en, ph_rs};
  assign m_axis_tlast  = ph_last;

  // ---------------------------------------------------------------- checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a phase is pending");

  a_first_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (m_axis_tvalid && (seg_q == SEG_POWER) && (sub_q == SUB_SETUP)))
    else $error("command did not start at its first phase");

  a_pulse_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ph_en) |-> (ph_hold == HOLD_PULSE))
    else $error("enable pulse with wrong hold");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && !tmr_busy && ph_last) |=> s_axis_tready)
    else $error("block not idle after last phase");

endmodule

### design/lcd4_timer.sv
// ----------------------------------------------------------------------------
// lcd4_timer
// Phase hold timer: microsecond prescaler plus a microsecond down-counter.
// ----------------------------------------------------------------------------
module lcd4_timer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             cpu_i,
  input  lcd4_pkg::lcd4_tmr_req_t req_i,
  output logic                   busy_o
);
  import lcd4_pkg::*;

  logic        busy_q, busy_d;
  logic [12:0] us_q, us_d;
  logic [7:0]  pre_q, pre_d;

  always_comb begin
    busy_d = busy_q;
    us_d   = us_q;
    pre_d  = pre_q;
    if (req_i.start) begin
      // zero hold or zero rate: nothing to wait for
      busy_d = (req_i.hold_us != HOLD_NONE) && (cpu_i != 8'd0);
      us_d   = req_i.hold_us;
      pre_d  = cpu_i - 8'd1;
    end else if (busy_q) begin
      if (pre_q == 8'd0) begin
        pre_d = cpu_i - 8'd1;
        if (us_q == 13'd1) begin
          busy_d = 1'b0;
        end else begin
          us_d = us_q - 13'd1;
        end
      end else begin
        pre_d = pre_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      us_q   <= '0;
      pre_q  <= '0;
    end else begin
      busy_q <= busy_d;
      us_q   <= us_d;
      pre_q  <= pre_d;
    end
  end

  assign busy_o = busy_q;

endmodule
